FILE: rtl/msw_pkg.sv
`timescale 1ns / 1ps
// Package for the multi sine wave pattern generator.
// Holds the widths and constants shared by the block; depends on nothing.
package msw_pkg;

	localparam int unsigned PixW     = 6;
	localparam int unsigned TimeW    = 32;
	localparam int unsigned FreqW    = 16;
	localparam int unsigned PhaseW   = 32;
	localparam int unsigned ProdW    = 28;
	localparam int unsigned PW       = 29;
	localparam int unsigned DenW     = 33;
	localparam int unsigned RemW     = 46;
	localparam int unsigned QuoW     = 13;
	localparam int unsigned SineW    = 14;
	localparam int unsigned AccW     = 18;
	localparam int unsigned OutW     = 16;
	localparam int unsigned InDataW  = 40;
	localparam int unsigned CfgIdxW  = 2;
	localparam int unsigned NumLanes = 3;

	typedef enum logic [CfgIdxW-1:0] {
		REG_FREQ_ONE   = 2'd0,
		REG_FREQ_TWO   = 2'd1,
		REG_FREQ_THREE = 2'd2,
		REG_NONE       = 2'd3
	} cfg_reg_t;

	localparam logic [DenW-1:0]  DenBase   = 33'h1_4000_0000;
	localparam logic [QuoW-1:0]  MagMax    = 13'd4096;
	localparam logic [AccW-1:0]  OffOne    = 18'd8192;
	localparam logic [AccW-1:0]  OffFifth  = 18'd1638;

endpackage

FILE: rtl/multi_sine_wave_pattern.sv
`timescale 1ns / 1ps
// Top level of the multi sine wave pattern generator, one module.
// Depends on msw_pkg for widths and register codes.
//
// Usage: each input transaction on the s_ side carries a pixel index and a
// time value; exactly one output transaction on the m_ side follows with the
// weighted sum of up to three Bhaskara sines in signed Q3.12.
// The three frequency registers are written over the cfg_ channel, which is
// always ready; they must only be changed while the pipeline is empty.
// Throughput is one transaction per cycle while the receiver does not stall:
// the pipeline has a multiplier stage, a phase adder stage, a sine product
// stage, a divider setup stage, thirteen restoring divider stages (one
// quotient bit each) and the output register.
// Every stage has its own valid bit and moves forward when the next stage is
// empty or moving, so bubbles collapse and a stall at m_tready backs up
// stage by stage without losing or repeating anything; s_tready falls only
// once every stage is full.
// Reset clears all valid bits and sets the frequency registers to zero.
module multi_sine_wave_pattern #(
	parameter int unsigned PIXELS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// Fields from bit 0: pixel_index[5:0], time_value[37:6], zero pad.
	input  logic [msw_pkg::InDataW-1:0]   s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// Fields from bit 0: wave_sum[15:0].
	output logic [msw_pkg::OutW-1:0]      m_tdata,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [msw_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [msw_pkg::FreqW-1:0]     cfg_data
);
	import msw_pkg::*;

	localparam int unsigned NumDiv  = QuoW + 1;
	localparam int unsigned NumStg  = 3 + NumDiv + 1;
	localparam int unsigned OutStg  = NumStg - 1;
	localparam int unsigned NumPix  = 1 << PixW;

	logic [FreqW-1:0] freq_q [NumLanes];
	logic [PhaseW-1:0] pix_tab [NumPix];

	logic [NumStg-1:0] vld_q;
	logic [NumStg:0]   adv;

	logic [PhaseW-1:0] base_s1;
	logic [ProdW-1:0]  prod_s1 [NumLanes];
	logic [PhaseW-1:0] ph_s2 [NumLanes];
	logic [PW-1:0]     p_s3 [NumLanes];
	logic              neg_s3 [NumLanes];

	logic [RemW-1:0] rem_sd [NumDiv][NumLanes];
	logic [DenW-1:0] den_sd [NumDiv][NumLanes];
	logic [QuoW-1:0] quo_sd [NumDiv][NumLanes];
	logic            neg_sd [NumDiv][NumLanes];

	logic [OutW-1:0] sum_q;

	logic [PixW-1:0]  in_pix;
	logic [TimeW-1:0] in_time;
	logic             zero_two;
	logic             zero_three;

	assign in_pix     = s_tdata[PixW-1:0];
	assign in_time    = s_tdata[PixW+TimeW-1:PixW];
	assign cfg_ready  = 1'b1;
	assign zero_two   = (freq_q[1] == '0);
	assign zero_three = (freq_q[2] == '0);

	for (genvar k = 0; k < NumPix; k++) begin : g_pix
		localparam logic [63:0] Entry = (64'(k % PIXELS) << 32) / 64'(PIXELS);
		assign pix_tab[k] = Entry[PhaseW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumLanes; i++) freq_q[i] <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_FREQ_ONE:   freq_q[0] <= cfg_data;
				REG_FREQ_TWO:   freq_q[1] <= cfg_data;
				REG_FREQ_THREE: freq_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		adv[NumStg] = m_tready;
		for (int i = NumStg - 1; i >= 0; i--) adv[i] = !vld_q[i] || adv[i+1];
	end
	assign s_tready = adv[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) vld_q[0] <= s_tvalid;
			for (int i = 1; i < NumStg; i++) begin
				if (adv[i]) vld_q[i] <= vld_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			base_s1 <= pix_tab[in_pix];
			for (int l = 0; l < NumLanes; l++) begin
				prod_s1[l] <= ProdW'(in_time[ProdW-1:0]
					* {{(ProdW-FreqW){freq_q[l][FreqW-1]}}, freq_q[l]});
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			for (int l = 0; l < NumLanes; l++) begin
				ph_s2[l] <= base_s1 + {prod_s1[l], 4'b0000};
			end
		end
	end

	logic [62:0] sq_prod [NumLanes];
	always_comb begin
		for (int l = 0; l < NumLanes; l++) begin
			sq_prod[l] = 63'(ph_s2[l][PhaseW-2:0])
				* 63'(32'h8000_0000 - {1'b0, ph_s2[l][PhaseW-2:0]});
		end
	end

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			for (int l = 0; l < NumLanes; l++) begin
				p_s3[l]   <= sq_prod[l][60:32];
				neg_s3[l] <= ph_s2[l][PhaseW-1];
			end
		end
	end

	logic [DenW-1:0] den_init [NumLanes];
	always_comb begin
		for (int l = 0; l < NumLanes; l++) den_init[l] = DenBase - {2'b00, p_s3[l], 2'b00};
	end

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			for (int l = 0; l < NumLanes; l++) begin
				rem_sd[0][l] <= {1'b0, p_s3[l], 16'h0000} + RemW'(den_init[l] >> 1);
				den_sd[0][l] <= den_init[l];
				quo_sd[0][l] <= '0;
				neg_sd[0][l] <= neg_s3[l];
			end
		end
	end

	for (genvar j = 1; j < NumDiv; j++) begin : g_div
		localparam int unsigned Bit = QuoW - j;
		logic [RemW-1:0] trial [NumLanes];
		always_comb begin
			for (int l = 0; l < NumLanes; l++) trial[l] = RemW'(den_sd[j-1][l]) << Bit;
		end
		always_ff @(posedge clk) begin
			if (adv[3+j]) begin
				for (int l = 0; l < NumLanes; l++) begin
					den_sd[j][l] <= den_sd[j-1][l];
					neg_sd[j][l] <= neg_sd[j-1][l];
					if (rem_sd[j-1][l] >= trial[l]) begin
						rem_sd[j][l]      <= rem_sd[j-1][l] - trial[l];
						quo_sd[j][l]      <= quo_sd[j-1][l] | (QuoW'(1) << Bit);
					end else begin
						rem_sd[j][l]      <= rem_sd[j-1][l];
						quo_sd[j][l]      <= quo_sd[j-1][l];
					end
				end
			end
		end
	end

	logic signed [SineW-1:0] sine [NumLanes];
	logic signed [AccW-1:0]  acc;
	logic signed [AccW-1:0]  half;
	logic [OutW-1:0]         sat;
	always_comb begin
		for (int l = 0; l < NumLanes; l++) begin
			sine[l] = neg_sd[NumDiv-1][l] ? -$signed({1'b0, quo_sd[NumDiv-1][l]})
				: $signed({1'b0, quo_sd[NumDiv-1][l]});
		end
		if (zero_two && zero_three) begin
			acc = AccW'(2) * AccW'(sine[0]);
		end else if (zero_two) begin
			acc = $signed(OffFifth) + AccW'(3) * AccW'(sine[0]) + AccW'(sine[2]);
		end else if (zero_three) begin
			acc = $signed(OffOne) + AccW'(3) * AccW'(sine[0])
				+ AccW'(2) * AccW'(sine[1]);
		end else begin
			acc = $signed(OffOne) + AccW'(3) * AccW'(sine[0])
				+ AccW'(2) * AccW'(sine[1]) + AccW'(sine[2]);
		end
		half = (acc + AccW'(1)) >>> 1;
		if (half > AccW'(32767)) sat = 16'h7FFF;
		else if (half < -AccW'(32768)) sat = 16'h8000;
		else sat = half[OutW-1:0];
	end

	always_ff @(posedge clk) begin
		if (adv[OutStg]) sum_q <= sat;
	end

	assign m_tvalid = vld_q[OutStg];
	assign m_tdata  = sum_q;

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q == '0) |-> s_tready)
		else $error("input not ready with an empty pipeline");
	a_mag_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[OutStg-1] |-> (quo_sd[NumDiv-1][0] <= MagMax
			&& quo_sd[NumDiv-1][1] <= MagMax && quo_sd[NumDiv-1][2] <= MagMax))
		else $error("sine magnitude above one");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[OutStg] && !m_tready) |=> (vld_q[OutStg] && $stable(sum_q)))
		else $error("output register changed during a stall");

endmodule

FILE: tb/multi_sine_wave_pattern_test.sv
`timescale 1ns / 1ps
// Self-checking test of multi_sine_wave_pattern: drives pixel/time transactions under random
// idling, predicts each weighted Bhaskara sine sum and compares results in order.
// Depends on msw_pkg and the multi_sine_wave_pattern RTL.

class wave_sum_board;
	bit signed [15:0] f1, f2, f3;
	logic [15:0] sums_due[$];
	int errors;

	function new();
		f1 = 0;
		f2 = 0;
		f3 = 0;
		errors = 0;
	endfunction

	function logic [31:0] phase_of(logic [5:0] pix, logic [31:0] t, bit signed [15:0] f);
		logic [31:0] base;
		logic [63:0] prod;
		base = {pix, 26'd0};
		prod = {32'd0, t} * {{48{f[15]}}, f};
		return base + {prod[27:0], 4'd0};
	endfunction

	function int signed sine_of(logic [31:0] ph);
		logic [63:0] u, p30, num, den, mag;
		u = {33'd0, ph[30:0]};
		p30 = (u * (64'h8000_0000 - u)) >> 32;
		num = p30 << 16;
		den = (64'd5 << 30) - (p30 << 2);
		mag = (num + (den >> 1)) / den;
		return ph[31] ? -int'(mag) : int'(mag);
	endfunction

	function void note_input(logic [5:0] pix, logic [31:0] t);
		int signed s1, s2, s3, acc, r;
		s1 = sine_of(phase_of(pix, t, f1));
		s2 = sine_of(phase_of(pix, t, f2));
		s3 = sine_of(phase_of(pix, t, f3));
		if (f2 == 0 && f3 == 0)
			acc = 2 * s1;
		else if (f2 == 0)
			acc = 1638 + 3 * s1 + s3;
		else if (f3 == 0)
			acc = 8192 + 3 * s1 + 2 * s2;
		else
			acc = 8192 + 3 * s1 + 2 * s2 + s3;
		r = (acc + 1) >>> 1;
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		sums_due.push_back(r[15:0]);
	endfunction

	function void check_result(logic [15:0] got);
		logic [15:0] want;
		if (sums_due.size() == 0) begin
			$display("%0t: unexpected result, expected none, actual %h", $time, got);
			errors++;
			return;
		end
		want = sums_due.pop_front();
		if (got !== want) begin
			$display("%0t: wave_sum mismatch, expected %h, actual %h", $time, want, got);
			errors++;
		end
	endfunction
endclass

module multi_sine_wave_pattern_test;
	import msw_pkg::*;

	logic clk, arst_n;
	logic s_tvalid, s_tready, m_tvalid, m_tready;
	logic [InDataW-1:0] s_tdata;
	logic [OutW-1:0] m_tdata;
	logic cfg_valid, cfg_ready;
	logic [CfgIdxW-1:0] cfg_index;
	logic [FreqW-1:0] cfg_data;
	wave_sum_board board;
	bit calm;
	int idle_cycles;

	multi_sine_wave_pattern u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) board.check_result(m_tdata);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("[multi_sine_wave_pattern] ERROR");
			$finish;
		end
	end

	initial begin
		int n;
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 4);
				m_tready = 0;
				repeat (n - 1) @(negedge clk);
			end else begin
				m_tready = 1;
			end
		end
	end

	task automatic write_freq(cfg_reg_t idx, logic [15:0] value);
		@(negedge clk);
		cfg_valid = 1;
		cfg_index = idx;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_FREQ_ONE: board.f1 = value;
			REG_FREQ_TWO: board.f2 = value;
			REG_FREQ_THREE: board.f3 = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 0;
	endtask

	task automatic send_pixel(logic [5:0] pix, logic [31:0] t);
		if (!calm && $urandom_range(0, 5) == 0)
			repeat ($urandom_range(1, 4)) @(negedge clk);
		s_tvalid = 1;
		s_tdata = {2'b00, t, pix};
		do @(posedge clk); while (!s_tready);
		board.note_input(pix, t);
		@(negedge clk);
		s_tvalid = 0;
	endtask

	task automatic drain();
		while (board.sums_due.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic set_freqs(logic [15:0] a, logic [15:0] b, logic [15:0] c);
		write_freq(REG_FREQ_ONE, a);
		write_freq(REG_FREQ_TWO, b);
		write_freq(REG_FREQ_THREE, c);
	endtask

	function automatic logic [15:0] pick_freq();
		case ($urandom_range(0, 4))
			0: return 16'h0000;
			1: return 16'h7FFF;
			2: return 16'h8000;
			default: return 16'($urandom());
		endcase
	endfunction

	initial begin
		logic [15:0] mode_freqs[4][3];
		board = new();
		calm = 0;
		idle_cycles = 0;
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		cfg_valid = 0;
		cfg_index = REG_FREQ_ONE;
		cfg_data = '0;
		repeat (9) @(negedge clk);
		arst_n = 1;

		// Reset frequencies, then each weighting mode with extreme values.
		send_pixel(6'd0, 32'd0);
		send_pixel(6'd63, 32'hFFFF_FFFF);
		drain();
		mode_freqs = '{'{16'h7FFF, 16'h0000, 16'h0000}, '{16'h8000, 16'h0000, 16'h7FFF},
			'{16'h0000, 16'h8000, 16'h0000}, '{16'h7FFF, 16'h8000, 16'h8000}};
		foreach (mode_freqs[m]) begin
			set_freqs(mode_freqs[m][0], mode_freqs[m][1], mode_freqs[m][2]);
			send_pixel(6'd0, 32'd0);
			send_pixel(6'd16, 32'd0);
			send_pixel(6'd48, 32'h0001_0000);
			send_pixel(6'd63, 32'hFFFF_FFFF);
			send_pixel(6'd32, 32'hAAAA_5555);
			drain();
		end

		for (int ph = 0; ph < 20; ph++) begin
			if (ph == 16) calm = 1;
			set_freqs(pick_freq(), ph % 4 < 2 ? 16'h0000 : pick_freq(),
				ph % 2 == 0 ? 16'h0000 : pick_freq());
			repeat (63) send_pixel(6'($urandom()), $urandom());
			drain();
		end

		if (board.errors == 0)
			$display("[multi_sine_wave_pattern] OK");
		else
			$display("[multi_sine_wave_pattern] ERROR");
		$finish;
	end
endmodule
